/* hw/rtl/tva_pkg.sv */
package tva_pkg;

	// Geometry and format constants
	localparam int COORD_WIDTH   = 16;
	localparam int CORDIC_STAGES = 16;
	localparam int TABLE_LEN     = 24;
	localparam int CORDIC_ITERS  = (CORDIC_STAGES < TABLE_LEN) ? CORDIC_STAGES : TABLE_LEN;
	localparam int NORM_BIT      = 29;

	localparam int DIFF_W  = COORD_WIDTH + 1;        // edge vector component
	localparam int PROD_W  = 2 * DIFF_W;             // signed product
	localparam int MAG_W   = 2 * COORD_WIDTH + 1;    // |cross|, |dot|
	localparam int SUM_W   = MAG_W + 1;              // signed cross / dot
	localparam int POS_W   = $clog2(MAG_W);          // leading-one position
	localparam int NRM_W   = NORM_BIT + 1;           // normalised magnitude
	localparam int SHW_W   = MAG_W + NORM_BIT;       // pre-shift word
	localparam int CW      = NORM_BIT + 5;           // CORDIC x/y, headroom for gain
	localparam int Z_W     = 26;                     // angle accumulator, deg Q.16
	localparam int ANGLE_W = 16;

	localparam logic [ANGLE_W-1:0]  ANGLE_MAX   = ANGLE_W'(46080);
	localparam logic signed [Z_W-1:0] Z_RIGHT   = Z_W'(90 * 65536);
	localparam logic signed [Z_W-1:0] Z_ROUND   = Z_W'(128);

	typedef struct packed {
		logic valid;
		logic collinear;
	} tva_ctl_t;

	// atan(2^-i) in degrees, Q.16, rounded to nearest
	function automatic logic signed [Z_W-1:0] atan_q16(input int i);
		logic signed [Z_W-1:0] r;
		unique case (i)
			0:       r = Z_W'(2949120);
			1:       r = Z_W'(1740967);
			2:       r = Z_W'(919879);
			3:       r = Z_W'(466945);
			4:       r = Z_W'(234379);
			5:       r = Z_W'(117304);
			6:       r = Z_W'(58666);
			7:       r = Z_W'(29335);
			8:       r = Z_W'(14668);
			9:       r = Z_W'(7334);
			10:      r = Z_W'(3667);
			11:      r = Z_W'(1833);
			12:      r = Z_W'(917);
			13:      r = Z_W'(458);
			14:      r = Z_W'(229);
			15:      r = Z_W'(115);
			16:      r = Z_W'(57);
			17:      r = Z_W'(29);
			18:      r = Z_W'(14);
			19:      r = Z_W'(7);
			20:      r = Z_W'(4);
			21:      r = Z_W'(2);
			22:      r = Z_W'(1);
			default: r = '0;
		endcase
		return r;
	endfunction

endpackage

/* hw/rtl/tva_cordic.sv */
// Unrolled vectoring CORDIC, one micro-rotation per register stage.
module tva_cordic import tva_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  en,
	input  tva_ctl_t              ctl_i,
	input  logic signed [CW-1:0]  x_i,
	input  logic signed [CW-1:0]  y_i,
	input  logic signed [Z_W-1:0] z_i,
	output tva_ctl_t              ctl_o,
	output logic signed [Z_W-1:0] z_o
);

	tva_ctl_t              ctl_s [CORDIC_ITERS];
	logic signed [CW-1:0]  x_s   [CORDIC_ITERS];
	logic signed [CW-1:0]  y_s   [CORDIC_ITERS];
	logic signed [Z_W-1:0] z_s   [CORDIC_ITERS];

	tva_ctl_t              ctl_in [CORDIC_ITERS];
	logic signed [CW-1:0]  x_in   [CORDIC_ITERS];
	logic signed [CW-1:0]  y_in   [CORDIC_ITERS];
	logic signed [Z_W-1:0] z_in   [CORDIC_ITERS];

	for (genvar g = 0; g < CORDIC_ITERS; g++) begin : g_stage
		logic signed [CW-1:0] xs, ys;

		if (g == 0) begin : g_first
			assign ctl_in[g] = ctl_i;
			assign x_in[g]   = x_i;
			assign y_in[g]   = y_i;
			assign z_in[g]   = z_i;
		end else begin : g_next
			assign ctl_in[g] = ctl_s[g-1];
			assign x_in[g]   = x_s[g-1];
			assign y_in[g]   = y_s[g-1];
			assign z_in[g]   = z_s[g-1];
		end

		assign xs = x_in[g] >>> g;
		assign ys = y_in[g] >>> g;

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				ctl_s[g] <= '0;
			end else if (en) begin
				ctl_s[g] <= ctl_in[g];
			end
		end

		// rotate towards y = 0
		always_ff @(posedge clk) begin
			if (en) begin
				if (y_in[g] > 0) begin
					x_s[g] <= x_in[g] + ys;
					y_s[g] <= y_in[g] - xs;
					z_s[g] <= z_in[g] + atan_q16(g);
				end else begin
					x_s[g] <= x_in[g] - ys;
					y_s[g] <= y_in[g] + xs;
					z_s[g] <= z_in[g] - atan_q16(g);
				end
			end
		end
	end

	assign ctl_o = ctl_s[CORDIC_ITERS-1];
	assign z_o   = z_s[CORDIC_ITERS-1];

endmodule

/* hw/rtl/triangle_vertex_angle_core.sv */
// Angle ABC of three points, in degrees as unsigned Q8.8 (0 to 180.0). Each input word
// carries A, B and C as signed coordinates; the block forms BA and BC, their exact cross
// and dot products, and evaluates atan2(|cross|, dot) with an unrolled CORDIC after
// scaling the larger magnitude to a fixed bit position. A zero cross product (collinear,
// straight or coincident points) sets collinear and returns an angle of 0. The block is
// a fully pipelined datapath: one word is taken every cycle unless a held result is
// stalled. It has six front-end stages (difference, multiply, sum, magnitude, leading-one
// detect, normalise), one stage per CORDIC iteration and the rounding output register.
// out_stall freezes the whole pipeline and is passed straight back on in_stall while a
// result is held, so nothing is dropped or repeated.
module triangle_vertex_angle_core import tva_pkg::*; (
	input  logic                          clk,
	input  logic                          arst_n,

	input  logic                          in_valid,
	output logic                          in_stall,
	input  logic signed [COORD_WIDTH-1:0] ax,
	input  logic signed [COORD_WIDTH-1:0] ay,
	input  logic signed [COORD_WIDTH-1:0] bx,
	input  logic signed [COORD_WIDTH-1:0] by_coord,
	input  logic signed [COORD_WIDTH-1:0] cx,
	input  logic signed [COORD_WIDTH-1:0] cy,

	output logic                          out_valid,
	input  logic                          out_stall,
	output logic [ANGLE_W-1:0]            angle_deg,
	output logic                          collinear
);

	// Global advance: the pipeline moves unless a held result is being stalled.
	logic adv;
	assign adv      = !(out_valid && out_stall);
	assign in_stall = !adv;

	// ---- stage 1: edge vectors BA, BC
	logic                     v_s1;
	logic signed [DIFF_W-1:0] bax_s1, bay_s1, bcx_s1, bcy_s1;

	// ---- stage 2: the four products
	logic                     v_s2;
	logic signed [PROD_W-1:0] pxx_s2, pyy_s2, pxy_s2, pyx_s2;

	// ---- stage 3: cross and dot
	logic                     v_s3;
	logic signed [SUM_W-1:0]  cross_s3, dot_s3;

	// ---- stage 4: magnitudes, signs, collinear flag
	tva_ctl_t                 ctl_s4;
	logic                     dneg_s4;
	logic [MAG_W-1:0]         mx_s4, my_s4;

	// ---- stage 5: leading-one position of |dot| | |cross|
	tva_ctl_t                 ctl_s5;
	logic                     dneg_s5;
	logic [MAG_W-1:0]         mx_s5, my_s5;
	logic [POS_W-1:0]         pos_s5;

	// ---- stage 6: normalised, pre-rotated CORDIC start vector
	tva_ctl_t                 ctl_s6;
	logic signed [CW-1:0]     x_s6, y_s6;
	logic signed [Z_W-1:0]    z_s6;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1   <= 1'b0;
			v_s2   <= 1'b0;
			v_s3   <= 1'b0;
			ctl_s4 <= '0;
			ctl_s5 <= '0;
			ctl_s6 <= '0;
		end else if (adv) begin
			v_s1   <= in_valid;
			v_s2   <= v_s1;
			v_s3   <= v_s2;
			ctl_s4 <= '{valid: v_s3, collinear: (cross_s3 == '0)};
			ctl_s5 <= ctl_s4;
			ctl_s6 <= ctl_s5;
		end
	end

	// stage 1
	always_ff @(posedge clk) begin
		if (adv) begin
			bax_s1 <= DIFF_W'(ax) - DIFF_W'(bx);
			bay_s1 <= DIFF_W'(ay) - DIFF_W'(by_coord);
			bcx_s1 <= DIFF_W'(cx) - DIFF_W'(bx);
			bcy_s1 <= DIFF_W'(cy) - DIFF_W'(by_coord);
		end
	end

	// stage 2
	always_ff @(posedge clk) begin
		if (adv) begin
			pxx_s2 <= PROD_W'(bax_s1) * PROD_W'(bcx_s1);
			pyy_s2 <= PROD_W'(bay_s1) * PROD_W'(bcy_s1);
			pxy_s2 <= PROD_W'(bax_s1) * PROD_W'(bcy_s1);
			pyx_s2 <= PROD_W'(bay_s1) * PROD_W'(bcx_s1);
		end
	end

	// stage 3
	always_ff @(posedge clk) begin
		if (adv) begin
			cross_s3 <= SUM_W'(pxy_s2) - SUM_W'(pyx_s2);
			dot_s3   <= SUM_W'(pxx_s2) + SUM_W'(pyy_s2);
		end
	end

	// stage 4: only |cross| matters for the angle, the sign of dot picks the half plane
	logic signed [SUM_W-1:0] cross_abs, dot_abs;
	assign cross_abs = cross_s3[SUM_W-1] ? -cross_s3 : cross_s3;
	assign dot_abs   = dot_s3[SUM_W-1]   ? -dot_s3   : dot_s3;

	always_ff @(posedge clk) begin
		if (adv) begin
			dneg_s4 <= dot_s3[SUM_W-1];
			mx_s4   <= dot_abs[MAG_W-1:0];
			my_s4   <= cross_abs[MAG_W-1:0];
		end
	end

	// stage 5: priority encoder, highest set bit wins
	logic [MAG_W-1:0] both;
	logic [POS_W-1:0] pos;
	assign both = mx_s4 | my_s4;

	always_comb begin
		pos = '0;
		for (int k = 0; k < MAG_W; k++) begin
			if (both[k]) begin
				pos = POS_W'(k);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			dneg_s5 <= dneg_s4;
			mx_s5   <= mx_s4;
			my_s5   <= my_s4;
			pos_s5  <= pos;
		end
	end

	// stage 6: scale by 2^(NORM_BIT - pos) as one right shift of a pre-padded word,
	// truncating toward zero; then fold an obtuse angle into the right half plane.
	logic [SHW_W-1:0]     mx_wide, my_wide;
	logic [NRM_W-1:0]     mx_n, my_n;
	logic signed [CW-1:0] x_pos, y_pos, x_sgn;

	assign mx_wide = {mx_s5, {NORM_BIT{1'b0}}} >> pos_s5;
	assign my_wide = {my_s5, {NORM_BIT{1'b0}}} >> pos_s5;
	assign mx_n    = mx_wide[NRM_W-1:0];
	assign my_n    = my_wide[NRM_W-1:0];
	assign x_pos   = $signed(CW'(mx_n));
	assign y_pos   = $signed(CW'(my_n));
	assign x_sgn   = dneg_s5 ? -x_pos : x_pos;

	always_ff @(posedge clk) begin
		if (adv) begin
			if (x_sgn < 0) begin
				// rotate by -90 degrees: (x, y) -> (y, -x)
				x_s6 <= y_pos;
				y_s6 <= -x_sgn;
				z_s6 <= Z_RIGHT;
			end else begin
				x_s6 <= x_sgn;
				y_s6 <= y_pos;
				z_s6 <= '0;
			end
		end
	end

	// CORDIC
	tva_ctl_t              ctl_c;
	logic signed [Z_W-1:0] z_c;

	tva_cordic u_cordic (
		.clk    (clk),
		.arst_n (arst_n),
		.en     (adv),
		.ctl_i  (ctl_s6),
		.x_i    (x_s6),
		.y_i    (y_s6),
		.z_i    (z_s6),
		.ctl_o  (ctl_c),
		.z_o    (z_c)
	);

	// output: clamp at 0, round half up to Q8.8, clamp at 180 degrees
	logic signed [Z_W-1:0] z_pos, z_rnd;
	logic [ANGLE_W-1:0]    angle_c;

	assign z_pos   = (z_c < 0) ? '0 : z_c;
	assign z_rnd   = (z_pos + Z_ROUND) >>> 8;
	assign angle_c = (z_rnd > $signed(Z_W'(ANGLE_MAX))) ? ANGLE_MAX : z_rnd[ANGLE_W-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (adv) begin
			out_valid <= ctl_c.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			collinear <= ctl_c.collinear;
			angle_deg <= ctl_c.collinear ? '0 : angle_c;
		end
	end

endmodule

/* verif/tb_top.sv */
`timescale 1ns / 100ps

// Stand-alone bench for the triangle vertex angle core.
// A short directed set goes in first: corners of the coordinate range, right, acute,
// obtuse and straight angles, coincident points and cross products so small that they
// vanish after scaling. About 1500 random triangles follow, mostly shaped (collinear
// runs, near-straight angles, corner values) around a core of fully random words.
// The run goes through four handshake phases, and one long output hold-off fills the
// pipe so that in_stall rises. Every result is checked against a predictor that
// works the angle out with its own copy of the scaling and the CORDIC.
module tb_top;
	import tva_pkg::*;

	localparam int WORDS_PER_PHASE = 375;
	localparam int HOLD_CYCLES     = 300;      // long receiver hold-off
	localparam int DRAIN_CYCLES    = 40;       // > pipe latency
	localparam int CYCLE_LIMIT     = 400000;   // watchdog
	localparam int NORM_POS        = 29;       // top bit after scaling
	localparam longint RIGHT_Q16   = 90 * 65536;
	localparam longint ANGLE_TOP   = 46080;    // 180.0 in Q8.8

	// atan(2^-i) in degrees, Q.16
	localparam longint ATAN_DEG_Q16 [0:23] = '{
		2949120, 1740967, 919879, 466945, 234379, 117304, 58666, 29335,
		14668, 7334, 3667, 1833, 917, 458, 229, 115,
		57, 29, 14, 7, 4, 2, 1, 0
	};

	typedef struct {
		logic signed [COORD_WIDTH-1:0] ax;
		logic signed [COORD_WIDTH-1:0] ay;
		logic signed [COORD_WIDTH-1:0] bx;
		logic signed [COORD_WIDTH-1:0] by_coord;
		logic signed [COORD_WIDTH-1:0] cx;
		logic signed [COORD_WIDTH-1:0] cy;
	} tri_word_t;

	typedef struct packed {
		logic [ANGLE_W-1:0] angle;
		logic               collinear;
	} angle_res_t;

	// Holds the angles still owed by the core, oldest first.
	class angle_scoreboard;
		angle_res_t angle_due[$];
		int n_words;
		int n_checked;
		int n_collinear;
		int n_obtuse;
		int n_errors;

		// Angle ABC: exact cross/dot, scale the larger magnitude to bit 29,
		// then a vectoring CORDIC on (dot, |cross|) in degrees Q.16.
		function angle_res_t predict_angle(tri_word_t w);
			longint bax, bay, bcx, bcy, crs, dt, mx, my, both;
			longint x, y, z, t, xs, ys, q;
			int p;
			bit dneg;
			angle_res_t r;
			bax = longint'(w.ax) - longint'(w.bx);
			bay = longint'(w.ay) - longint'(w.by_coord);
			bcx = longint'(w.cx) - longint'(w.bx);
			bcy = longint'(w.cy) - longint'(w.by_coord);
			crs = bax * bcy - bay * bcx;
			dt  = bax * bcx + bay * bcy;
			r.angle = '0;
			r.collinear = 1'b1;
			if (crs == 0) begin
				return r;
			end
			r.collinear = 1'b0;
			my = (crs < 0) ? -crs : crs;
			dneg = (dt < 0);
			mx = dneg ? -dt : dt;
			both = mx | my;
			p = 63;
			while (p > 0 && !both[p]) p--;
			if (p > NORM_POS) begin
				mx = mx >> (p - NORM_POS);   // truncates, magnitudes are positive
				my = my >> (p - NORM_POS);
			end else begin
				mx = mx << (NORM_POS - p);
				my = my << (NORM_POS - p);
			end
			x = dneg ? -mx : mx;
			y = my;
			z = 0;
			// obtuse: rotate by 90 first so the CORDIC stays in range
			if (x < 0) begin
				t = y;
				y = -x;
				x = t;
				z = RIGHT_Q16;
			end
			for (int i = 0; i < CORDIC_ITERS; i++) begin
				xs = x >>> i;
				ys = y >>> i;
				if (y > 0) begin
					x += ys;
					y -= xs;
					z += ATAN_DEG_Q16[i];
				end else begin
					x -= ys;
					y += xs;
					z -= ATAN_DEG_Q16[i];
				end
			end
			if (z < 0) z = 0;
			q = (z + 128) >>> 8;
			if (q > ANGLE_TOP) q = ANGLE_TOP;
			r.angle = q[ANGLE_W-1:0];
			return r;
		endfunction

		function void note_word(tri_word_t w);
			angle_res_t r;
			longint dt;
			r = predict_angle(w);
			dt = (longint'(w.ax) - w.bx) * (longint'(w.cx) - w.bx)
				+ (longint'(w.ay) - w.by_coord) * (longint'(w.cy) - w.by_coord);
			n_words++;
			if (r.collinear) n_collinear++;
			else if (dt < 0) n_obtuse++;
			angle_due.push_back(r);
		endfunction

		function void check_result(logic [ANGLE_W-1:0] angle, logic col);
			angle_res_t exp_r;
			if (angle_due.size() == 0) begin
				$display("%0t: result with no word outstanding: angle_deg %0d collinear %0b",
					$time, angle, col);
				n_errors++;
				return;
			end
			exp_r = angle_due.pop_front();
			n_checked++;
			if (angle !== exp_r.angle) begin
				$display("%0t: angle_deg expected %0d got %0d", $time, exp_r.angle, angle);
				n_errors++;
			end
			if (col !== exp_r.collinear) begin
				$display("%0t: collinear expected %0b got %0b", $time, exp_r.collinear, col);
				n_errors++;
			end
		endfunction

		function int pending();
			return angle_due.size();
		endfunction
	endclass

	logic clk;
	logic arst_n;
	logic in_valid;
	logic in_stall;
	logic signed [COORD_WIDTH-1:0] ax, ay, bx, by_coord, cx, cy;
	logic out_valid;
	logic out_stall;
	logic [ANGLE_W-1:0] angle_deg;
	logic collinear;

	angle_scoreboard sb;
	int send_idle_pct;     // sender gap rate, in percent
	int recv_stall_pct;    // receiver stall rate, in percent
	bit hold_req;          // asks the receiver for one long hold-off
	int cycle_cnt;

	triangle_vertex_angle_core dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.ax        (ax),
		.ay        (ay),
		.bx        (bx),
		.by_coord  (by_coord),
		.cx        (cx),
		.cy        (cy),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.angle_deg (angle_deg),
		.collinear (collinear)
	);

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	// Watchdog: a healthy run finishes well inside this limit.
	initial begin
		cycle_cnt = 0;
		while (cycle_cnt < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_cnt++;
		end
		$display("[FAIL] regression broken");
		$finish;
	end

	// Receiver: random stall at the set rate, or one long hold-off on request.
	// The hold is counted here, so the sender keeps offering words meanwhile.
	initial begin
		out_stall = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_req) begin
				hold_req = 1'b0;
				out_stall <= 1'b1;
				repeat (HOLD_CYCLES - 1) @(negedge clk);
			end else begin
				out_stall <= ($urandom_range(99) < recv_stall_pct);
			end
		end
	end

	// Sample both channels on the rising edge; results first, so a stray result
	// cannot hide behind a word taken in the same cycle.
	always @(posedge clk) begin
		if (arst_n) begin
			if (out_valid && !out_stall)
				sb.check_result(angle_deg, collinear);
			if (in_valid && !in_stall)
				sb.note_word('{ax, ay, bx, by_coord, cx, cy});
		end
	end

	function automatic int span_rand(int span);
		return int'($urandom_range(2 * span)) - span;
	endfunction

	function automatic logic signed [COORD_WIDTH-1:0] corner_value();
		case ($urandom_range(5))
			0: return 16'h8000;
			1: return 16'h8001;
			2: return 16'hFFFF;
			3: return 16'h0000;
			4: return 16'h0001;
			default: return 16'h7FFF;
		endcase
	endfunction

	// Random triangle. Half the shapes aim at the awkward corners: exact collinear
	// runs, near-straight lines with a unit kink, points on the vertex, corners.
	function automatic tri_word_t random_word();
		tri_word_t w;
		int px, py, dx, dy, k;
		px = span_rand(1000);
		py = span_rand(1000);
		case ($urandom_range(9))
			0, 1, 2: begin
				w.ax = COORD_WIDTH'($urandom);
				w.ay = COORD_WIDTH'($urandom);
				w.bx = COORD_WIDTH'($urandom);
				w.by_coord = COORD_WIDTH'($urandom);
				w.cx = COORD_WIDTH'($urandom);
				w.cy = COORD_WIDTH'($urandom);
			end
			3: begin
				w.ax = COORD_WIDTH'(span_rand(16));
				w.ay = COORD_WIDTH'(span_rand(16));
				w.bx = COORD_WIDTH'(span_rand(16));
				w.by_coord = COORD_WIDTH'(span_rand(16));
				w.cx = COORD_WIDTH'(span_rand(16));
				w.cy = COORD_WIDTH'(span_rand(16));
			end
			4: begin
				// exactly collinear: C = B + k * (A - B)
				dx = span_rand(100);
				dy = span_rand(100);
				k = span_rand(4);
				w.bx = COORD_WIDTH'(px);
				w.by_coord = COORD_WIDTH'(py);
				w.ax = COORD_WIDTH'(px + dx);
				w.ay = COORD_WIDTH'(py + dy);
				w.cx = COORD_WIDTH'(px + k * dx);
				w.cy = COORD_WIDTH'(py + k * dy);
			end
			5: begin
				// one end point sits on the vertex
				w.bx = COORD_WIDTH'($urandom);
				w.by_coord = COORD_WIDTH'($urandom);
				w.ax = COORD_WIDTH'($urandom);
				w.ay = COORD_WIDTH'($urandom);
				w.cx = w.bx;
				w.cy = w.by_coord;
				if ($urandom_range(1)) begin
					w.cx = w.ax;
					w.cy = w.ay;
					w.ax = w.bx;
					w.ay = w.by_coord;
				end
			end
			6: begin
				w.ax = corner_value();
				w.ay = corner_value();
				w.bx = corner_value();
				w.by_coord = corner_value();
				w.cx = corner_value();
				w.cy = corner_value();
			end
			7: begin
				// near 0 or 180: long arms with at most a unit kink
				dx = span_rand(5000);
				dy = span_rand(5000);
				k = span_rand(3);
				w.bx = COORD_WIDTH'(px);
				w.by_coord = COORD_WIDTH'(py);
				w.ax = COORD_WIDTH'(px + dx);
				w.ay = COORD_WIDTH'(py + dy);
				w.cx = COORD_WIDTH'(px + k * dx + span_rand(1));
				w.cy = COORD_WIDTH'(py + k * dy + span_rand(1));
			end
			8: begin
				w.bx = COORD_WIDTH'(span_rand(256));
				w.by_coord = COORD_WIDTH'(span_rand(256));
				w.ax = corner_value();
				w.ay = corner_value();
				w.cx = corner_value();
				w.cy = corner_value();
			end
			default: begin
				w.ax = COORD_WIDTH'(span_rand(4096));
				w.ay = COORD_WIDTH'(span_rand(4096));
				w.bx = COORD_WIDTH'(span_rand(4096));
				w.by_coord = COORD_WIDTH'(span_rand(4096));
				w.cx = COORD_WIDTH'(span_rand(4096));
				w.cy = COORD_WIDTH'(span_rand(4096));
			end
		endcase
		return w;
	endfunction

	// Offer one word from a falling edge, hold it until taken, and return on
	// the falling edge after the accepting rising edge.
	task automatic send_word(input tri_word_t w);
		while ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		in_valid <= 1'b1;
		ax <= w.ax;
		ay <= w.ay;
		bx <= w.bx;
		by_coord <= w.by_coord;
		cx <= w.cx;
		cy <= w.cy;
		do @(posedge clk); while (in_stall);
		@(negedge clk);
	endtask

	task automatic send_coords(input int a0, a1, b0, b1, c0, c1);
		tri_word_t w;
		w.ax = COORD_WIDTH'(a0);
		w.ay = COORD_WIDTH'(a1);
		w.bx = COORD_WIDTH'(b0);
		w.by_coord = COORD_WIDTH'(b1);
		w.cx = COORD_WIDTH'(c0);
		w.cy = COORD_WIDTH'(c1);
		send_word(w);
	endtask

	task automatic send_random(input int count, input bit with_hold);
		for (int n = 0; n < count; n++) begin
			if (with_hold && n == 100) hold_req = 1'b1;
			send_word(random_word());
		end
	endtask

	initial begin
		sb = new();
		arst_n = 1'b0;
		in_valid = 1'b0;
		ax = '0;
		ay = '0;
		bx = '0;
		by_coord = '0;
		cx = '0;
		cy = '0;
		hold_req = 1'b0;
		send_idle_pct = 0;
		recv_stall_pct = 0;
		repeat (10) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// Phase 1: back to back, directed set first
		send_coords(0, 0, 0, 0, 0, 0);                       // all coincident
		send_coords(5, 5, 5, 5, 9, -3);                      // A on the vertex
		send_coords(1, 2, -7, 4, -7, 4);                     // C on the vertex
		send_coords(10, 0, 0, 0, 0, 10);                     // right angle
		send_coords(0, 10, 0, 0, 10, 0);                     // right angle, other turn
		send_coords(10, 0, 0, 0, 10, 10);                    // 45
		send_coords(10, 0, 0, 0, -10, 10);                   // 135, obtuse
		send_coords(2, 0, 0, 0, 1, 2);
		send_coords(10, 0, 0, 0, -20, 0);                    // straight line
		send_coords(10, 10, 0, 0, 3, 3);                     // same direction
		send_coords(1, 0, 0, 0, -1000, 1);                   // nearly straight
		send_coords(32767, 32767, -32768, -32768, -32768, 32767);
		send_coords(-32768, -32768, 32767, 32767, 32767, -32768);
		send_coords(-32768, -32768, -32768, -32768, -32768, -32768);
		send_coords(32767, 32767, 32767, 32767, 32767, 32767);
		send_coords(32767, -32768, 0, -1, -32768, 32767);
		send_coords(-32768, 0, 32767, 0, 32767, 32767);
		send_coords(0, 32767, 0, -32768, -32768, -32768);
		// unit cross product lost in scaling: clamps at 0 and at 180
		send_coords(32767, 32766, 0, 0, 32766, 32765);
		send_coords(32767, 32766, 0, 0, -32766, -32765);
		send_coords(32767, 32766, -32768, -32768, 32766, 32765);

		send_random(WORDS_PER_PHASE, 1'b1);   // includes the long hold-off

		// Phase 2: sender mostly idle
		send_idle_pct = 81;
		send_random(WORDS_PER_PHASE, 1'b0);

		// Phase 3: receiver mostly stalling
		send_idle_pct = 0;
		recv_stall_pct = 81;
		send_random(WORDS_PER_PHASE, 1'b0);

		// Phase 4: both sides idle now and then
		send_idle_pct = 32;
		recv_stall_pct = 32;
		send_random(WORDS_PER_PHASE, 1'b0);
		in_valid <= 1'b0;

		while (sb.pending() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("Covered %0d triangles (%0d collinear or coincident, %0d obtuse) in %0d cycles,",
			sb.n_words, sb.n_collinear, sb.n_obtuse, cycle_cnt);
		$display("%0d angles checked over four handshake phases and one long hold-off, %0d mismatches",
			sb.n_checked, sb.n_errors);
		if (sb.n_errors == 0) begin
			$display("[ OK ] regression clean");
		end else begin
			$display("[FAIL] regression broken");
		end
		$finish;
	end

endmodule
